// ----- sv/hbp_pkg.sv -----
// shared constants, types and codes of the heightmap box pyramid
package hbp_pkg;

  localparam int LEVELS      = 3;
  localparam int MAX_RES     = 512;
  localparam int HALF_RES    = (MAX_RES + 1) / 2;

  localparam int CFG_W       = 10;
  localparam int BASE_RESET  = 257;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam int H_W         = 24;
  localparam int PAIR_W      = H_W + 1;
  localparam int SUM_W       = H_W + 2;
  localparam int LVL_W       = 3;
  localparam int POS_W       = 9;

  localparam int RES_W       = $clog2(MAX_RES + 1);
  localparam int CNT_W       = $clog2(MAX_RES);
  localparam int ADDR_W      = CNT_W - 1;
  localparam int WIDE_W      = (RES_W > CFG_W) ? RES_W : CFG_W;
  localparam int NRES_W      = $clog2(LEVELS + 1);

  localparam int OFIFO_DEPTH = 16;
  localparam int OPTR_W      = $clog2(OFIFO_DEPTH);
  localparam int OCNT_W      = $clog2(OFIFO_DEPTH + 1);

  // register index, taken from the word address
  typedef enum logic [0:0] {
    REG_BASE_RES = 1'b0
  } reg_idx_t;

  // one finished result
  typedef struct packed {
    logic [LVL_W-1:0]        level_index;
    logic [POS_W-1:0]        out_column;
    logic [POS_W-1:0]        out_row;
    logic signed [H_W-1:0]   out_height;
    logic                    grid_done;
  } res_t;

  // what one item carries between levels
  typedef struct packed {
    res_t [LEVELS-1:0]       res;
    logic [NRES_W-1:0]       nres;
    logic                    go;
    logic signed [H_W-1:0]   cur;
  } flow_t;

  // one level's stage register, waiting on the line store read
  typedef struct packed {
    res_t [LEVELS-1:0]       res;
    logic [NRES_W-1:0]       nres;
    logic                    emit;
    logic                    add_mem;
    logic signed [SUM_W-1:0] val;
    logic [POS_W-1:0]        col;
    logic [POS_W-1:0]        row;
    logic                    done;
  } stage_t;

  // one entry of the result queue
  typedef struct packed {
    res_t                    res;
    logic                    run_last;
  } obeat_t;

endpackage

// ----- sv/hbp_chan_if.sv -----
// valid/ready channel interfaces for the sample and result streams
interface hbp_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [hbp_pkg::H_W-1:0] sample_height;

  modport source (output valid, output sample_height, input ready);
  modport sink   (input valid, input sample_height, output ready);
endinterface

interface hbp_out_if;
  logic                             valid;
  logic                             ready;
  logic [hbp_pkg::LVL_W-1:0]        level_index;
  logic [hbp_pkg::POS_W-1:0]        out_column;
  logic [hbp_pkg::POS_W-1:0]        out_row;
  logic signed [hbp_pkg::H_W-1:0]   out_height;
  logic                             run_last;
  logic                             grid_done;

  modport source (output valid, output level_index, output out_column, output out_row,
                  output out_height, output run_last, output grid_done, input ready);
  modport sink   (input valid, input level_index, input out_column, input out_row,
                  input out_height, input run_last, input grid_done, output ready);
endinterface

// ----- sv/heightmap_box_pyramid_unit.sv -----
// streaming 2x2 box-filter pyramid over a square heightmap, top level
//
//   channel   kind          beat contents
//   in_bus    valid/ready   sample_height, one base sample in raster order
//   out_bus   valid/ready   level_index, out_column, out_row, out_height,
//                           run_last, grid_done
//   apb       psel/penable  base_resolution at byte address 0
//
// one sample is taken per cycle while in_bus.ready is high; each level is one
// pipeline step, so the results of a sample pass through every level's stage
// register before they enter the result queue, and the first of them can leave in the cycle after.
// a sample yields up to LEVELS results, drained one beat per cycle while out_bus.ready
// is high from a 16-entry queue; in_bus.ready drops while that queue has no room for LEVELS.
// synchronous active-low reset clears counters, holds and the queue; the
// line store has no clearing pass, so the block is ready right after reset.
module heightmap_box_pyramid_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  hbp_in_if.sink                      in_bus,
  hbp_out_if.source                   out_bus,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hbp_pkg::APB_AW-1:0]  paddr,
  input  logic [hbp_pkg::APB_DW-1:0]  pwdata,
  output logic [hbp_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  // ---------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------
  logic [hbp_pkg::CFG_W-1:0] base_r;
  hbp_pkg::reg_idx_t         reg_idx;
  logic                      base_wr;

  assign reg_idx = hbp_pkg::reg_idx_t'(paddr[hbp_pkg::APB_AW-1]);
  assign base_wr = psel & penable & pwrite & (reg_idx == hbp_pkg::REG_BASE_RES);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == hbp_pkg::REG_BASE_RES) ?
                   hbp_pkg::APB_DW'(base_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= hbp_pkg::CFG_W'(hbp_pkg::BASE_RESET);
    end else if (base_wr) begin
      base_r <= pwdata[hbp_pkg::CFG_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // per-level parent resolution: clamp the base, then halve rounding up
  // ---------------------------------------------------------------------
  logic [hbp_pkg::WIDE_W-1:0] base_w;
  logic [hbp_pkg::RES_W-1:0]  lres [hbp_pkg::LEVELS+1];

  always_comb begin
    base_w = hbp_pkg::WIDE_W'(base_r);
    if (base_w < hbp_pkg::WIDE_W'(2)) begin
      base_w = hbp_pkg::WIDE_W'(2);
    end else if (base_w > hbp_pkg::WIDE_W'(hbp_pkg::MAX_RES)) begin
      base_w = hbp_pkg::WIDE_W'(hbp_pkg::MAX_RES);
    end
    lres[0] = hbp_pkg::RES_W'(base_w);
    for (int l = 0; l < hbp_pkg::LEVELS; l++) begin
      lres[l+1] = hbp_pkg::RES_W'(({1'b0, lres[l]} + 1'b1) >> 1);
    end
  end

  // ---------------------------------------------------------------------
  // level pipeline
  // ---------------------------------------------------------------------
  logic                      adv;      // whole pipeline moves
  logic                      in_acc;
  hbp_pkg::flow_t            flow [hbp_pkg::LEVELS+1];
  logic [hbp_pkg::LEVELS-1:0] st_emit;
  logic [hbp_pkg::OCNT_W-1:0] ocnt_r;

  // hold back input while the queue could not absorb a full cascade
  assign adv          = ocnt_r <= hbp_pkg::OCNT_W'(hbp_pkg::OFIFO_DEPTH - hbp_pkg::LEVELS);
  assign in_bus.ready = adv;
  assign in_acc       = in_bus.valid & adv;

  assign flow[0] = '{res: '0, nres: '0, go: in_acc, cur: in_bus.sample_height};

  for (genvar l = 0; l < hbp_pkg::LEVELS; l++) begin : g_lvl
    logic [hbp_pkg::CNT_W-1:0]        col_r, row_r;
    logic [hbp_pkg::CNT_W-1:0]        col_nxt, row_nxt;
    logic signed [hbp_pkg::H_W-1:0]   hold_r;
    logic signed [hbp_pkg::PAIR_W-1:0] line_mem [hbp_pkg::HALF_RES];
    logic signed [hbp_pkg::PAIR_W-1:0] rd_q;
    hbp_pkg::stage_t                  st_r, st_nxt;
    hbp_pkg::flow_t                   fin;

    logic [hbp_pkg::RES_W-1:0]        rm1, rout_m1, xo, zo;
    logic [hbp_pkg::ADDR_W-1:0]       addr;
    logic                             go, c_last, z_last, have, hold_ld;
    logic                             wr_en, rd_en, emit;
    logic signed [hbp_pkg::PAIR_W-1:0] cur_e, pair;
    logic signed [hbp_pkg::SUM_W-1:0] add, total;

    // column pairing, then row pairing through the line store
    always_comb begin
      go      = flow[l].go;
      rm1     = lres[l] - 1'b1;
      rout_m1 = lres[l+1] - 1'b1;
      c_last  = hbp_pkg::RES_W'(col_r) == rm1;
      z_last  = hbp_pkg::RES_W'(row_r) == rm1;
      cur_e   = hbp_pkg::PAIR_W'(flow[l].cur);
      addr    = col_r[hbp_pkg::CNT_W-1:1];
      xo      = hbp_pkg::RES_W'(addr);
      zo      = hbp_pkg::RES_W'(row_r[hbp_pkg::CNT_W-1:1]);

      if (col_r[0]) begin
        pair = hbp_pkg::PAIR_W'(hold_r) + cur_e;
        have = 1'b1;
      end else begin
        // last column of an odd-sized row pairs with itself
        pair = cur_e <<< 1;
        have = c_last;
      end
      hold_ld = go & ~col_r[0] & ~c_last;

      wr_en = go & have & ~row_r[0] & ~z_last;
      rd_en = adv & go & have & row_r[0];
      emit  = go & have & (row_r[0] | z_last);

      col_nxt = c_last ? '0 : col_r + 1'b1;
      if (c_last) begin
        row_nxt = z_last ? '0 : row_r + 1'b1;
      end else begin
        row_nxt = row_r;
      end

      st_nxt.res     = flow[l].res;
      st_nxt.nres    = flow[l].nres;
      st_nxt.emit    = emit;
      st_nxt.add_mem = row_r[0];
      // last row of an odd-sized level counts twice
      st_nxt.val     = row_r[0] ? hbp_pkg::SUM_W'(pair) : hbp_pkg::SUM_W'(pair) <<< 1;
      st_nxt.col     = hbp_pkg::POS_W'(addr);
      st_nxt.row     = hbp_pkg::POS_W'(row_r[hbp_pkg::CNT_W-1:1]);
      st_nxt.done    = (l == hbp_pkg::LEVELS - 1) && (xo == rout_m1) && (zo == rout_m1);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        col_r  <= '0;
        row_r  <= '0;
        hold_r <= '0;
      end else if (base_wr) begin
        col_r  <= '0;
        row_r  <= '0;
        hold_r <= '0;
      end else if (adv && go) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        if (hold_ld) begin
          hold_r <= flow[l].cur;
        end
      end
    end

    // line store: even rows write, odd rows read a full row later
    always_ff @(posedge clk) begin
      if (adv && wr_en) begin
        line_mem[addr] <= pair;
      end
      if (rd_en) begin
        rd_q <= line_mem[addr];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r.emit <= 1'b0;
        st_r.nres <= '0;
      end else if (adv) begin
        st_r <= st_nxt;
      end
    end

    // finish the level: add the stored row and take a floor quarter
    always_comb begin
      add   = st_r.add_mem ? hbp_pkg::SUM_W'(rd_q) : hbp_pkg::SUM_W'(0);
      total = st_r.val + add;
      fin.res  = st_r.res;
      fin.nres = st_r.nres;
      fin.go   = st_r.emit;
      fin.cur  = total[hbp_pkg::SUM_W-1:2];
      if (st_r.emit) begin
        fin.res[l]  = '{level_index: hbp_pkg::LVL_W'(l), out_column: st_r.col,
                        out_row: st_r.row, out_height: total[hbp_pkg::SUM_W-1:2],
                        grid_done: st_r.done};
        fin.nres    = hbp_pkg::NRES_W'(l + 1);
      end
    end

    assign flow[l+1]  = fin;
    assign st_emit[l] = st_r.emit;
  end

  // ---------------------------------------------------------------------
  // result queue
  // ---------------------------------------------------------------------
  hbp_pkg::obeat_t            ofifo [hbp_pkg::OFIFO_DEPTH];
  hbp_pkg::obeat_t            head;
  logic [hbp_pkg::OPTR_W-1:0] owr_r, ord_r;
  logic [hbp_pkg::NRES_W-1:0] push_n;
  logic                       pop;

  assign push_n = adv ? flow[hbp_pkg::LEVELS].nres : '0;
  assign pop    = out_bus.valid & out_bus.ready;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < hbp_pkg::LEVELS; i++) begin
        if (hbp_pkg::NRES_W'(i) < flow[hbp_pkg::LEVELS].nres) begin
          ofifo[owr_r + hbp_pkg::OPTR_W'(i)] <= '{
            res: flow[hbp_pkg::LEVELS].res[i],
            run_last: hbp_pkg::NRES_W'(i + 1) == flow[hbp_pkg::LEVELS].nres};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owr_r  <= owr_r + hbp_pkg::OPTR_W'(push_n);
      ord_r  <= ord_r + hbp_pkg::OPTR_W'(pop);
      ocnt_r <= ocnt_r + hbp_pkg::OCNT_W'(push_n) - hbp_pkg::OCNT_W'(pop);
    end
  end

  assign head                = ofifo[ord_r];
  assign out_bus.valid       = ocnt_r != '0;
  assign out_bus.level_index = head.res.level_index;
  assign out_bus.out_column  = head.res.out_column;
  assign out_bus.out_row     = head.res.out_row;
  assign out_bus.out_height  = head.res.out_height;
  assign out_bus.grid_done   = head.res.grid_done;
  assign out_bus.run_last    = head.run_last;

`ifndef ASSERT_OFF
  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= hbp_pkg::OCNT_W'(hbp_pkg::OFIFO_DEPTH))
    else $error("result queue overflow");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.grid_done |->
      out_bus.run_last && (out_bus.level_index == hbp_pkg::LVL_W'(hbp_pkg::LEVELS - 1)))
    else $error("grid end not on the deepest level's last beat");

  for (genvar l = 1; l < hbp_pkg::LEVELS; l++) begin : g_chain_chk
    a_emit_chain: assert property (@(posedge clk) disable iff (!rst_n)
      adv && !st_emit[l-1] |=> !st_emit[l])
      else $error("level emitted without a parent result");
  end
`endif

endmodule
